### rtl/mwem_pkg.sv
// ---------------------------------------------------------------------------
// mwem_pkg
// Shared types and constants for the three-wire serial EEPROM master.
// ---------------------------------------------------------------------------
package mwem_pkg;

   // default geometry of the attached EEPROM
   localparam int ADDR_BITS_DEF = 6;
   localparam int DATA_BITS_DEF = 16;

   // command codes
   localparam int CMD_W = 3;
   localparam logic [CMD_W-1:0] CMD_READ  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_WRITE = 3'd1;
   localparam logic [CMD_W-1:0] CMD_ERASE = 3'd2;
   localparam logic [CMD_W-1:0] CMD_WEN   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_WDS   = 3'd4;

   // opcodes sent on the wire after the start bit
   localparam logic [1:0] OPC_READ  = 2'b10;
   localparam logic [1:0] OPC_WRITE = 2'b01;
   localparam logic [1:0] OPC_ERASE = 2'b11;
   localparam logic [1:0] OPC_EXT   = 2'b00;

   // top two address bits that select write enable or write disable among the extended opcodes
   localparam logic [1:0] EXT_WEN_SEL = 2'b11;
   localparam logic [1:0] EXT_WDS_SEL = 2'b00;

   // result status codes
   localparam int STATUS_W = 2;
   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_TIMEOUT = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BUSY    = 2'd2;

   // ready poll counter
   localparam int POLL_W = 16;
   localparam logic [POLL_W-1:0] POLL_LIMIT_RESET = 16'hFFFF;

   // request kind
   localparam logic REQ_TICK = 1'b0;
   localparam logic REQ_CMD  = 1'b1;

   // phases of one serial bit
   localparam logic [1:0] PH_DRIVE = 2'd0;
   localparam logic [1:0] PH_RISE  = 2'd1;
   localparam logic [1:0] PH_FALL  = 2'd2;

   // sequencer mode
   typedef enum logic [2:0] {
      MODE_IDLE  = 3'b001,
      MODE_SHIFT = 3'b010,
      MODE_POLL  = 3'b100
   } mode_type;

   // classified item, control part
   typedef struct packed {
      logic is_cmd;
      logic cmd_ok;
      logic has_data;
      logic is_erase;
      logic serial_in;
   } item_ctl_type;

endpackage

### rtl/mwem_req_if.sv
// ---------------------------------------------------------------------------
// mwem_req_if
// Request channel: valid/ready handshake carrying one tick or command item.
// ---------------------------------------------------------------------------
interface mwem_req_if #(
   parameter int ADDR_BITS = mwem_pkg::ADDR_BITS_DEF,
   parameter int DATA_BITS = mwem_pkg::DATA_BITS_DEF
);
   logic                       valid;
   logic                       ready;
   logic                       req_type;
   logic [mwem_pkg::CMD_W-1:0] command;
   logic [ADDR_BITS-1:0]       word_address;
   logic [DATA_BITS-1:0]       write_word;
   logic                       serial_in;

   modport source (
      output valid, req_type, command, word_address, write_word, serial_in,
      input  ready
   );
   modport sink (
      input  valid, req_type, command, word_address, write_word, serial_in,
      output ready
   );
endinterface

### rtl/mwem_rsp_if.sv
// ---------------------------------------------------------------------------
// mwem_rsp_if
// Response channel: valid/ready handshake carrying pin levels and status.
// ---------------------------------------------------------------------------
interface mwem_rsp_if #(
   parameter int DATA_BITS = mwem_pkg::DATA_BITS_DEF
);
   logic                          valid;
   logic                          ready;
   logic                          chip_select;
   logic                          serial_clock;
   logic                          serial_out;
   logic                          busy_res;
   logic                          done_res;
   logic [DATA_BITS-1:0]          read_word;
   logic [mwem_pkg::STATUS_W-1:0] status;

   modport source (
      output valid, chip_select, serial_clock, serial_out, busy_res, done_res,
             read_word, status,
      input  ready
   );
   modport sink (
      input  valid, chip_select, serial_clock, serial_out, busy_res, done_res,
             read_word, status,
      output ready
   );
endinterface

### rtl/mwem_front.sv
// ---------------------------------------------------------------------------
// mwem_front
// Takes request items, classifies them and builds the serial frame of a
// command, left aligned, ready for the back end to shift out.
// ---------------------------------------------------------------------------
module mwem_front #(
   parameter int ADDR_BITS = mwem_pkg::ADDR_BITS_DEF,
   parameter int DATA_BITS = mwem_pkg::DATA_BITS_DEF,
   parameter int FRAME_W   = 3 + ADDR_BITS + DATA_BITS,
   parameter int BITS_W    = $clog2(FRAME_W + 1)
) (
   mwem_req_if.sink                 req_bus,
   output logic                     push_valid,
   input  logic                     push_ready,
   output mwem_pkg::item_ctl_type   push_ctl,
   output logic [FRAME_W-1:0]       push_frame,
   output logic [BITS_W-1:0]        push_bits
);
   import mwem_pkg::*;

   localparam int HDR_W = 3 + ADDR_BITS;

   logic [1:0]           opcode;
   logic [ADDR_BITS-1:0] addr;
   logic [HDR_W-1:0]     header;
   logic [DATA_BITS-1:0] data;

   // handshake toward the queue
   assign push_valid    = req_bus.valid;
   assign req_bus.ready = push_ready;

   // opcode and address per command
   always_comb begin
      opcode = OPC_EXT;
      addr   = req_bus.word_address;
      case (req_bus.command)
         CMD_READ:  opcode = OPC_READ;
         CMD_WRITE: opcode = OPC_WRITE;
         CMD_ERASE: opcode = OPC_ERASE;
         CMD_WEN:   addr   = {EXT_WEN_SEL, {(ADDR_BITS-2){1'b0}}};
         CMD_WDS:   addr   = {EXT_WDS_SEL, {(ADDR_BITS-2){1'b0}}};
         default:   addr   = req_bus.word_address;
      endcase
   end

   // classification
   always_comb begin
      push_ctl.is_cmd    = (req_bus.req_type == REQ_CMD);
      push_ctl.cmd_ok    = (req_bus.command <= CMD_WDS);
      push_ctl.has_data  = (req_bus.command == CMD_READ) ||
                           (req_bus.command == CMD_WRITE);
      push_ctl.is_erase  = (req_bus.command == CMD_ERASE);
      push_ctl.serial_in = req_bus.serial_in;
   end

   // frame: start bit, opcode, address, then data bits or padding
   assign header     = {1'b1, opcode, addr};
   assign data       = (req_bus.command == CMD_WRITE) ? req_bus.write_word
                                                      : '0;
   assign push_frame = {header, data};
   assign push_bits  = push_ctl.has_data ? BITS_W'(FRAME_W) : BITS_W'(HDR_W);

endmodule

### rtl/mwem_queue.sv
// ---------------------------------------------------------------------------
// mwem_queue
// Small register FIFO between the front end and the back end.
// ---------------------------------------------------------------------------
module mwem_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);
   import mwem_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign in_ready  = (count_ff != CNT_W'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_data  = store_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

### rtl/mwem_back.sv
// ---------------------------------------------------------------------------
// mwem_back
// Serial sequencer: steps the pin phases of each frame bit, captures read
// data, polls ready after erase and registers one response per item.
// ---------------------------------------------------------------------------
module mwem_back #(
   parameter int ADDR_BITS = mwem_pkg::ADDR_BITS_DEF,
   parameter int DATA_BITS = mwem_pkg::DATA_BITS_DEF,
   parameter int FRAME_W   = 3 + ADDR_BITS + DATA_BITS,
   parameter int BITS_W    = $clog2(FRAME_W + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_en,
   input  logic [mwem_pkg::POLL_W-1:0]   csr_write_data,
   input  logic                          pop_valid,
   output logic                          pop_ready,
   input  mwem_pkg::item_ctl_type        pop_ctl,
   input  logic [FRAME_W-1:0]            pop_frame,
   input  logic [BITS_W-1:0]             pop_bits,
   mwem_rsp_if.source                    rsp_bus
);
   import mwem_pkg::*;

   // configuration
   logic [POLL_W-1:0]    poll_limit_ff;

   // sequencer state
   mode_type             mode_ff, mode_in;
   logic [1:0]           phase_ff, phase_in;
   logic [BITS_W-1:0]    bits_ff, bits_in;
   logic [FRAME_W-1:0]   frame_ff, frame_in;
   logic [DATA_BITS-1:0] capture_ff, capture_in;
   logic [POLL_W-1:0]    poll_ff, poll_in;
   logic                 has_data_ff, has_data_in;
   logic                 is_erase_ff, is_erase_in;
   logic                 cs_ff, cs_in;
   logic                 ck_ff, ck_in;
   logic                 si_ff, si_in;

   // response register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 done_ff, done_in;
   logic [DATA_BITS-1:0] rword_ff, rword_in;
   logic [STATUS_W-1:0]  status_ff, status_in;

   logic                 take;

   assign pop_ready = !rsp_valid_ff || rsp_bus.ready;
   assign take      = pop_valid && pop_ready;

   // poll limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         poll_limit_ff <= POLL_LIMIT_RESET;
      end else if (csr_write_en) begin
         poll_limit_ff <= csr_write_data;
      end
   end

   // one item of work
   always_comb begin
      mode_in     = mode_ff;
      phase_in    = phase_ff;
      bits_in     = bits_ff;
      frame_in    = frame_ff;
      capture_in  = capture_ff;
      poll_in     = poll_ff;
      has_data_in = has_data_ff;
      is_erase_in = is_erase_ff;
      cs_in       = cs_ff;
      ck_in       = ck_ff;
      si_in       = si_ff;
      done_in     = 1'b0;
      rword_in    = '0;
      status_in   = STATUS_OK;

      if (pop_ctl.is_cmd) begin
         // new command: rejected while busy, unknown codes dropped
         if (mode_ff != MODE_IDLE) begin
            status_in = STATUS_BUSY;
         end else if (pop_ctl.cmd_ok) begin
            frame_in    = pop_frame;
            bits_in     = pop_bits;
            has_data_in = pop_ctl.has_data;
            is_erase_in = pop_ctl.is_erase;
            capture_in  = '0;
            poll_in     = '0;
            phase_in    = PH_DRIVE;
            mode_in     = MODE_SHIFT;
            cs_in       = 1'b1;
            ck_in       = 1'b0;
            si_in       = 1'b0;
         end
      end else begin
         case (mode_ff)
            MODE_SHIFT: begin
               case (phase_ff)
                  PH_DRIVE: begin
                     si_in    = frame_ff[FRAME_W-1];
                     ck_in    = 1'b0;
                     phase_in = PH_RISE;
                  end
                  PH_RISE: begin
                     ck_in    = 1'b1;
                     phase_in = PH_FALL;
                  end
                  default: begin
                     // falling edge: sample and move to the next bit
                     ck_in    = 1'b0;
                     frame_in = {frame_ff[FRAME_W-2:0], 1'b0};
                     if (has_data_ff && (bits_ff <= BITS_W'(DATA_BITS))) begin
                        capture_in = {capture_ff[DATA_BITS-2:0], pop_ctl.serial_in};
                     end
                     bits_in  = bits_ff - 1'b1;
                     phase_in = PH_DRIVE;
                     if (bits_ff == BITS_W'(1)) begin
                        cs_in = 1'b0;
                        if (is_erase_ff) begin
                           mode_in = MODE_POLL;
                        end else begin
                           mode_in  = MODE_IDLE;
                           done_in  = 1'b1;
                           rword_in = capture_in;
                        end
                     end
                  end
               endcase
            end
            MODE_POLL: begin
               if (phase_ff == PH_DRIVE) begin
                  cs_in    = 1'b1;
                  phase_in = PH_RISE;
               end else if (pop_ctl.serial_in) begin
                  cs_in    = 1'b0;
                  mode_in  = MODE_IDLE;
                  phase_in = PH_DRIVE;
                  done_in  = 1'b1;
               end else begin
                  poll_in = poll_ff + 1'b1;
                  if (poll_in >= poll_limit_ff) begin
                     cs_in     = 1'b0;
                     mode_in   = MODE_IDLE;
                     phase_in  = PH_DRIVE;
                     done_in   = 1'b1;
                     status_in = STATUS_TIMEOUT;
                  end
               end
            end
            default: begin
               // tick while idle: nothing moves
               mode_in = MODE_IDLE;
            end
         endcase
      end
   end

   // response valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_IDLE;
         phase_ff     <= PH_DRIVE;
         bits_ff      <= '0;
         frame_ff     <= '0;
         capture_ff   <= '0;
         poll_ff      <= '0;
         has_data_ff  <= 1'b0;
         is_erase_ff  <= 1'b0;
         cs_ff        <= 1'b0;
         ck_ff        <= 1'b0;
         si_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            mode_ff     <= mode_in;
            phase_ff    <= phase_in;
            bits_ff     <= bits_in;
            frame_ff    <= frame_in;
            capture_ff  <= capture_in;
            poll_ff     <= poll_in;
            has_data_ff <= has_data_in;
            is_erase_ff <= is_erase_in;
            cs_ff       <= cs_in;
            ck_ff       <= ck_in;
            si_ff       <= si_in;
         end
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (take) begin
         done_ff   <= done_in;
         rword_ff  <= rword_in;
         status_ff <= status_in;
      end
   end

   // pins mirror the state that the transfer just left behind
   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.chip_select  = cs_ff;
   assign rsp_bus.serial_clock = ck_ff;
   assign rsp_bus.serial_out   = si_ff;
   assign rsp_bus.busy_res     = (mode_ff != MODE_IDLE);
   assign rsp_bus.done_res     = done_ff;
   assign rsp_bus.read_word    = rword_ff;
   assign rsp_bus.status       = status_ff;

endmodule

### rtl/microwire_eeprom_master_top.sv
// ---------------------------------------------------------------------------
// microwire_eeprom_master_top
// Three-wire serial master for a word-organized serial EEPROM, stepped one
// pin phase per tick item.
// ---------------------------------------------------------------------------
// Every request item (a command or a tick) produces exactly one response
// carrying the chip select, clock and data-in pin levels after that item,
// busy, done, the captured read word and a status code. The block takes one
// item per clock cycle while the receiver takes responses: the front end
// classifies it and builds the frame in the cycle it arrives, a two-entry
// queue holds it, and the back end retires it into an output register.
// A frame needs three ticks per bit; after an erase, ticks poll the ready
// level until it reads high or the poll limit written through the csr port
// is reached. The poll limit resets to 65535; the user must write it only
// while no command is in progress, as the block does not enforce this.
// ---------------------------------------------------------------------------
module microwire_eeprom_master_top #(
   parameter int ADDR_BITS = mwem_pkg::ADDR_BITS_DEF,
   parameter int DATA_BITS = mwem_pkg::DATA_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_en,
   input  logic [mwem_pkg::POLL_W-1:0]   csr_write_data,
   mwem_req_if.sink                      req_bus,
   mwem_rsp_if.source                    rsp_bus
);
   import mwem_pkg::*;

   localparam int FRAME_W = 3 + ADDR_BITS + DATA_BITS;
   localparam int BITS_W  = $clog2(FRAME_W + 1);
   localparam int CTL_W   = $bits(item_ctl_type);
   localparam int ITEM_W  = CTL_W + FRAME_W + BITS_W;

   logic               push_valid, push_ready;
   item_ctl_type       push_ctl;
   logic [FRAME_W-1:0] push_frame;
   logic [BITS_W-1:0]  push_bits;

   logic               pop_valid, pop_ready;
   logic [ITEM_W-1:0]  pop_item;
   item_ctl_type       pop_ctl;
   logic [FRAME_W-1:0] pop_frame;
   logic [BITS_W-1:0]  pop_bits;

   // classify and build frames
   mwem_front #(
      .ADDR_BITS (ADDR_BITS),
      .DATA_BITS (DATA_BITS),
      .FRAME_W   (FRAME_W),
      .BITS_W    (BITS_W)
   ) u_front (
      .req_bus    (req_bus),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_ctl   (push_ctl),
      .push_frame (push_frame),
      .push_bits  (push_bits)
   );

   // decoupling queue
   mwem_queue #(
      .WIDTH (ITEM_W),
      .DEPTH (2)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_data   ({push_ctl, push_frame, push_bits}),
      .out_valid (pop_valid),
      .out_ready (pop_ready),
      .out_data  (pop_item)
   );

   assign {pop_ctl, pop_frame, pop_bits} = pop_item;

   // serial sequencer and response register
   mwem_back #(
      .ADDR_BITS (ADDR_BITS),
      .DATA_BITS (DATA_BITS),
      .FRAME_W   (FRAME_W),
      .BITS_W    (BITS_W)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .pop_valid      (pop_valid),
      .pop_ready      (pop_ready),
      .pop_ctl        (pop_ctl),
      .pop_frame      (pop_frame),
      .pop_bits       (pop_bits),
      .rsp_bus        (rsp_bus)
   );

endmodule

### test/tb_microwire_eeprom_master_top.sv
// ---------------------------------------------------------------------------
// tb_microwire_eeprom_master_top
// Self-checking bench for the three-wire serial EEPROM master. Walks a short
// table of commands and tick bursts, then random command frames with ticks
// under several idling and poll limit settings. Every result transfer is
// compared with a bench-side model of the pin sequencer or a table row's result.
// ---------------------------------------------------------------------------
module tb_microwire_eeprom_master_top;
   timeunit 1ns;
   timeprecision 1ps;

   import mwem_pkg::*;

   localparam int AW = ADDR_BITS_DEF;
   localparam int DW = DATA_BITS_DEF;
   localparam int FW = 3 + AW + DW;

   localparam int CYCLE_LIMIT   = 1000000;
   localparam int SETTLE_CYCLES = 4;
   localparam int DRAIN_CYCLES  = 10;
   localparam int HOLD_CYCLES   = 300;
   localparam int PHASE_ITEMS   = 240;
   localparam int NUM_PHASES    = 5;
   localparam int PRESSURE_PH   = 4;

   // command codes with no meaning to the block
   localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd5;
   localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;

   typedef struct packed {
      logic                req_type;
      logic [CMD_W-1:0]    command;
      logic [AW-1:0]       word_address;
      logic [DW-1:0]       write_word;
      logic                serial_in;
   } req_item_type;

   typedef struct packed {
      logic                cs;
      logic                ck;
      logic                so;
      logic                busy;
      logic                done;
      logic [DW-1:0]       rword;
      logic [STATUS_W-1:0] status;
   } pin_result_type;

   // one table row: a single item, or a burst of ticks with a serial_in pattern
   typedef struct packed {
      logic                req_type;
      logic [CMD_W-1:0]    command;
      logic [AW-1:0]       word_address;
      logic [DW-1:0]       write_word;
      int                  reps;
      logic [31:0]         sin_bits;
      int                  sin_step;
      logic                typed;
      pin_result_type      want;
   } dir_row_type;

   localparam pin_result_type RES_IDLE    = '0;
   localparam pin_result_type RES_STARTED =
      pin_result_type'{1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 16'h0000, STATUS_OK};
   localparam pin_result_type RES_REJECT  =
      pin_result_type'{1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 16'h0000, STATUS_BUSY};

   logic clock;
   logic reset;
   logic csr_write_en;
   logic [POLL_W-1:0] csr_write_data;

   mwem_req_if req_ch ();
   mwem_rsp_if rsp_ch ();

   microwire_eeprom_master_top dut (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_bus        (req_ch),
      .rsp_bus        (rsp_ch)
   );

   // sequencer model state
   mode_type          em_mode;
   logic [1:0]        em_phase;
   logic [4:0]        em_bits_left;
   logic [FW-1:0]     em_frame;
   logic [DW-1:0]     em_capture;
   logic [POLL_W-1:0] em_poll_count;
   logic [POLL_W-1:0] em_poll_limit;
   logic [CMD_W-1:0]  em_cmd;
   logic              em_cs, em_ck, em_si;

   pin_result_type pins_pending[$];
   dir_row_type    dir_tab[$];

   int sender_idle_pct = 0;
   int rcv_stall_pct   = 0;
   int hold_requests   = 0;
   int hold_served     = 0;
   int hold_left       = 0;
   int cycle_count     = 0;
   int live_items      = 0;
   int mismatches      = 0;
   int results_seen    = 0;
   int done_seen       = 0;
   int timeouts_seen   = 0;
   int rejects_seen    = 0;

   always #5 clock = ~clock;

   // model of one item: advances the sequencer and returns the pins after it
   function automatic pin_result_type predict_pins(input req_item_type it);
      pin_result_type r;
      logic        data_cmd;
      logic        bit_now;
      logic [1:0]  opc;
      logic [AW-1:0] adr;
      r        = '0;
      data_cmd = (em_cmd == CMD_READ) || (em_cmd == CMD_WRITE);
      if (it.req_type == REQ_CMD) begin
         if (em_mode != MODE_IDLE) begin
            r.status = STATUS_BUSY;
         end else if (it.command <= CMD_WDS) begin
            adr = it.word_address;
            case (it.command)
               CMD_READ:  opc = OPC_READ;
               CMD_WRITE: opc = OPC_WRITE;
               CMD_ERASE: opc = OPC_ERASE;
               CMD_WEN: begin
                  opc = OPC_EXT;
                  adr = {EXT_WEN_SEL, {(AW-2){1'b0}}};
               end
               default: begin
                  opc = OPC_EXT;
                  adr = {EXT_WDS_SEL, {(AW-2){1'b0}}};
               end
            endcase
            if (it.command == CMD_READ || it.command == CMD_WRITE) begin
               em_frame     = {1'b1, opc, adr,
                               (it.command == CMD_WRITE) ? it.write_word : {DW{1'b0}}};
               em_bits_left = 5'(FW);
            end else begin
               em_frame     = {{DW{1'b0}}, 1'b1, opc, adr};
               em_bits_left = 5'(3 + AW);
            end
            em_cmd        = it.command;
            em_capture    = '0;
            em_poll_count = '0;
            em_phase      = PH_DRIVE;
            em_mode       = MODE_SHIFT;
            em_cs         = 1'b1;
            em_ck         = 1'b0;
            em_si         = 1'b0;
         end
      end else if (em_mode == MODE_SHIFT) begin
         bit_now = em_frame[em_bits_left - 5'd1];
         case (em_phase)
            PH_DRIVE: begin
               em_si    = bit_now;
               em_ck    = 1'b0;
               em_phase = PH_RISE;
            end
            PH_RISE: begin
               em_ck    = 1'b1;
               em_phase = PH_FALL;
            end
            default: begin
               em_ck = 1'b0;
               // data bits shift the sampled line in, msb first
               if (data_cmd && em_bits_left <= 5'(DW))
                  em_capture = {em_capture[DW-2:0], it.serial_in};
               em_bits_left = em_bits_left - 5'd1;
               em_phase     = PH_DRIVE;
               if (em_bits_left == 5'd0) begin
                  em_cs = 1'b0;
                  if (em_cmd == CMD_ERASE) begin
                     em_mode = MODE_POLL;
                  end else begin
                     em_mode = MODE_IDLE;
                     r.done  = 1'b1;
                     r.rword = em_capture;
                  end
               end
            end
         endcase
      end else if (em_mode == MODE_POLL) begin
         // first poll tick raises chip select, later ones sample ready
         if (em_phase == PH_DRIVE) begin
            em_cs    = 1'b1;
            em_phase = PH_RISE;
         end else if (it.serial_in) begin
            em_cs    = 1'b0;
            em_mode  = MODE_IDLE;
            em_phase = PH_DRIVE;
            r.done   = 1'b1;
         end else begin
            em_poll_count = em_poll_count + 1'b1;
            if (em_poll_count >= em_poll_limit) begin
               em_cs    = 1'b0;
               em_mode  = MODE_IDLE;
               em_phase = PH_DRIVE;
               r.done   = 1'b1;
               r.status = STATUS_TIMEOUT;
            end
         end
      end
      r.cs   = em_cs;
      r.ck   = em_ck;
      r.so   = em_si;
      r.busy = (em_mode != MODE_IDLE);
      return r;
   endfunction

   // offer one item, wait for its transfer, then queue its expected pins
   task automatic send_item(input req_item_type it, input logic use_typed,
                            input pin_result_type typed_res);
      int gap;
      pin_result_type predicted;
      gap = 0;
      while ($urandom_range(99) < sender_idle_pct) gap++;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.req_type     <= it.req_type;
      req_ch.command      <= it.command;
      req_ch.word_address <= it.word_address;
      req_ch.write_word   <= it.write_word;
      req_ch.serial_in    <= it.serial_in;
      req_ch.valid        <= 1'b1;
      do @(posedge clock); while (!req_ch.ready);
      if (em_mode != MODE_IDLE || (it.req_type == REQ_CMD && it.command <= CMD_WDS))
         live_items++;
      predicted = predict_pins(it);
      pins_pending.push_back(use_typed ? typed_res : predicted);
   endtask

   // drain, let the block settle, then write the poll limit
   task automatic set_poll_limit(input logic [POLL_W-1:0] value);
      req_ch.valid <= 1'b0;
      while (pins_pending.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      em_poll_limit   = value;
   endtask

   // one command frame with ticks until the block is idle again, or one noise item
   task automatic run_random_frame();
      req_item_type it;
      int roll;
      roll            = $urandom_range(99);
      it.req_type     = REQ_CMD;
      it.command      = 3'($urandom_range(CMD_WDS));
      it.word_address = 6'($urandom);
      it.write_word   = 16'($urandom);
      it.serial_in    = 1'($urandom);
      if (roll < 8) begin
         // noise while idle: a stray tick or an unused command code
         if (roll < 4) it.req_type = REQ_TICK;
         else it.command = 3'($urandom_range(CMD_UNUSED_HI, CMD_UNUSED_LO));
         send_item(it, 1'b0, RES_IDLE);
      end else begin
         if (roll < 30) it.command = CMD_ERASE;
         send_item(it, 1'b0, RES_IDLE);
         while (em_mode != MODE_IDLE) begin
            it.word_address = 6'($urandom);
            it.write_word   = 16'($urandom);
            it.serial_in    = 1'($urandom);
            if ($urandom_range(99) < 3) begin
               // command in the middle of a frame or a poll
               it.req_type = REQ_CMD;
               it.command  = 3'($urandom);
            end else begin
               it.req_type = REQ_TICK;
               if (em_mode == MODE_POLL) it.serial_in = ($urandom_range(5) == 0);
            end
            send_item(it, 1'b0, RES_IDLE);
         end
      end
   endtask

   task automatic check_field(input string fname, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, fname, want, got);
         mismatches++;
      end
   endtask

   // result side: compare every transfer with the oldest expectation
   always @(posedge clock) begin
      pin_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         results_seen++;
         if (rsp_ch.done_res === 1'b1) done_seen++;
         if (rsp_ch.status === STATUS_TIMEOUT) timeouts_seen++;
         if (rsp_ch.status === STATUS_BUSY) rejects_seen++;
         if (pins_pending.size() == 0) begin
            $display("%0t ns: result with nothing expected, expected none actual %0h",
                     $time, {rsp_ch.chip_select, rsp_ch.serial_clock, rsp_ch.serial_out,
                             rsp_ch.busy_res, rsp_ch.done_res, rsp_ch.read_word,
                             rsp_ch.status});
            mismatches++;
         end else begin
            want = pins_pending.pop_front();
            check_field("chip_select", 16'(want.cs), 16'(rsp_ch.chip_select));
            check_field("serial_clock", 16'(want.ck), 16'(rsp_ch.serial_clock));
            check_field("serial_out", 16'(want.so), 16'(rsp_ch.serial_out));
            check_field("busy_res", 16'(want.busy), 16'(rsp_ch.busy_res));
            check_field("done_res", 16'(want.done), 16'(rsp_ch.done_res));
            check_field("read_word", want.rword, rsp_ch.read_word);
            check_field("status", 16'(want.status), 16'(rsp_ch.status));
         end
      end
   end

   // receiver stalls, with a long hold-off on request
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ch.ready <= 1'b0;
      end else if (hold_served != hold_requests) begin
         hold_served = hold_requests;
         hold_left   = HOLD_CYCLES;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= rcv_stall_pct);
      end
   end

   // run timeout
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      req_item_type it;
      dir_row_type  row;
      int        ph;
      int        k;
      int        phase_start;
      logic      hold_asked;

      clock               = 1'b0;
      reset               = 1'b1;
      csr_write_en        = 1'b0;
      csr_write_data      = '0;
      req_ch.valid        = 1'b0;
      req_ch.req_type     = REQ_TICK;
      req_ch.command      = CMD_READ;
      req_ch.word_address = '0;
      req_ch.write_word   = '0;
      req_ch.serial_in    = 1'b0;
      rsp_ch.ready        = 1'b0;

      em_mode       = MODE_IDLE;
      em_phase      = PH_DRIVE;
      em_bits_left  = '0;
      em_frame      = '0;
      em_capture    = '0;
      em_poll_count = '0;
      em_poll_limit = POLL_LIMIT_RESET;
      em_cmd        = CMD_READ;
      em_cs         = 1'b0;
      em_ck         = 1'b0;
      em_si         = 1'b0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed table: idle cases, rejects, every command, extreme data
      dir_tab.push_back(dir_row_type'{REQ_TICK, CMD_READ, 6'd0, 16'h0000, 1,
                                      32'h0, 1, 1'b1, RES_IDLE});
      dir_tab.push_back(dir_row_type'{REQ_CMD, CMD_UNUSED_HI, 6'd63, 16'hFFFF, 1,
                                      32'h0, 1, 1'b1, RES_IDLE});
      dir_tab.push_back(dir_row_type'{REQ_CMD, CMD_UNUSED_LO, 6'd0, 16'h0000, 1,
                                      32'hFFFFFFFF, 1, 1'b1, RES_IDLE});
      dir_tab.push_back(dir_row_type'{REQ_CMD, CMD_WEN, 6'd63, 16'h0000, 1,
                                      32'h0, 1, 1'b1, RES_STARTED});
      dir_tab.push_back(dir_row_type'{REQ_CMD, CMD_READ, 6'd5, 16'h0000, 1,
                                      32'h0, 1, 1'b1, RES_REJECT});
      dir_tab.push_back(dir_row_type'{REQ_CMD, CMD_UNUSED_HI, 6'd5, 16'h0000, 1,
                                      32'h0, 1, 1'b1, RES_REJECT});
      dir_tab.push_back(dir_row_type'{REQ_TICK, CMD_READ, 6'd0, 16'h0000, 27,
                                      32'h0, 3, 1'b0, RES_IDLE});
      dir_tab.push_back(dir_row_type'{REQ_TICK, CMD_READ, 6'd0, 16'h0000, 1,
                                      32'h0, 1, 1'b1, RES_IDLE});
      dir_tab.push_back(dir_row_type'{REQ_CMD, CMD_WRITE, 6'd63, 16'hFFFF, 1,
                                      32'h0, 1, 1'b0, RES_IDLE});
      dir_tab.push_back(dir_row_type'{REQ_TICK, CMD_READ, 6'd0, 16'h0000, 75,
                                      32'hFFFFFFFF, 3, 1'b0, RES_IDLE});
      dir_tab.push_back(dir_row_type'{REQ_TICK, CMD_READ, 6'd0, 16'h0000, 1,
                                      32'h0, 1, 1'b0, RES_IDLE});
      dir_tab.push_back(dir_row_type'{REQ_CMD, CMD_READ, 6'd0, 16'h0000, 1,
                                      32'h0, 1, 1'b0, RES_IDLE});
      dir_tab.push_back(dir_row_type'{REQ_TICK, CMD_READ, 6'd0, 16'h0000, 75,
                                      {9'h0, 16'hFFFF, 7'h0}, 3, 1'b0, RES_IDLE});
      dir_tab.push_back(dir_row_type'{REQ_CMD, CMD_WRITE, 6'd0, 16'h0000, 1,
                                      32'h0, 1, 1'b0, RES_IDLE});
      dir_tab.push_back(dir_row_type'{REQ_TICK, CMD_READ, 6'd0, 16'h0000, 75,
                                      32'hAAAAAAAA, 3, 1'b0, RES_IDLE});
      dir_tab.push_back(dir_row_type'{REQ_CMD, CMD_ERASE, 6'd21, 16'h0000, 1,
                                      32'h0, 1, 1'b0, RES_IDLE});
      dir_tab.push_back(dir_row_type'{REQ_TICK, CMD_READ, 6'd0, 16'h0000, 27,
                                      32'h0, 3, 1'b0, RES_IDLE});
      dir_tab.push_back(dir_row_type'{REQ_TICK, CMD_READ, 6'd0, 16'h0000, 4,
                                      32'h10000000, 1, 1'b0, RES_IDLE});
      dir_tab.push_back(dir_row_type'{REQ_CMD, CMD_ERASE, 6'd42, 16'h0000, 1,
                                      32'h0, 1, 1'b0, RES_IDLE});
      dir_tab.push_back(dir_row_type'{REQ_TICK, CMD_READ, 6'd0, 16'h0000, 28,
                                      32'h0, 3, 1'b0, RES_IDLE});
      dir_tab.push_back(dir_row_type'{REQ_CMD, CMD_WDS, 6'd0, 16'h0000, 1,
                                      32'h0, 1, 1'b0, RES_IDLE});
      dir_tab.push_back(dir_row_type'{REQ_TICK, CMD_READ, 6'd0, 16'h0000, 1,
                                      32'h80000000, 1, 1'b0, RES_IDLE});
      dir_tab.push_back(dir_row_type'{REQ_CMD, CMD_WDS, 6'd63, 16'hFFFF, 1,
                                      32'h0, 1, 1'b0, RES_IDLE});
      dir_tab.push_back(dir_row_type'{REQ_TICK, CMD_READ, 6'd0, 16'h0000, 27,
                                      32'h0, 3, 1'b0, RES_IDLE});

      foreach (dir_tab[i]) begin
         row = dir_tab[i];
         for (k = 0; k < row.reps; k++) begin
            it.req_type     = row.req_type;
            it.command      = row.command;
            it.word_address = row.word_address;
            it.write_word   = row.write_word;
            it.serial_in    = row.sin_bits[31 - ((k / row.sin_step) % 32)];
            send_item(it, row.typed, row.want);
         end
      end

      // random frames under each idling and poll limit setting
      for (ph = 0; ph < NUM_PHASES; ph++) begin
         case (ph)
            0: set_poll_limit(16'd1);
            1: set_poll_limit(16'd0);
            2: set_poll_limit(16'hFFFF);
            3: set_poll_limit(16'($urandom_range(12, 2)));
            default: set_poll_limit(16'd4);
         endcase
         case (ph)
            1: begin sender_idle_pct = 81; rcv_stall_pct = 0; end
            2: begin sender_idle_pct = 0; rcv_stall_pct = 81; end
            3: begin sender_idle_pct = 7; rcv_stall_pct = 7; end
            default: begin sender_idle_pct = 0; rcv_stall_pct = 0; end
         endcase
         phase_start = live_items;
         hold_asked  = 1'b0;
         while (live_items - phase_start < PHASE_ITEMS) begin
            if (ph == PRESSURE_PH && !hold_asked && live_items - phase_start >= 20) begin
               hold_requests++;
               hold_asked = 1'b1;
            end
            run_random_frame();
         end
      end

      req_ch.valid <= 1'b0;
      while (pins_pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d live items: %0d results checked, %0d commands finished,",
               live_items, results_seen, done_seen);
      $display("%0d poll timeouts and %0d busy rejects across %0d random phases",
               timeouts_seen, rejects_seen, NUM_PHASES);
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

### sim.f
rtl/mwem_pkg.sv
rtl/mwem_req_if.sv
rtl/mwem_rsp_if.sv
rtl/mwem_front.sv
rtl/mwem_queue.sv
rtl/mwem_back.sv
rtl/microwire_eeprom_master_top.sv
test/tb_microwire_eeprom_master_top.sv
